### sv/idq_pkg.sv
`default_nettype none
package idq_pkg;

   // Operation codes carried in the func field
   localparam logic [3:0] FUNC_PUSH_BACK  = 4'd0;
   localparam logic [3:0] FUNC_PUSH_FRONT = 4'd1;
   localparam logic [3:0] FUNC_POP_BACK   = 4'd2;
   localparam logic [3:0] FUNC_POP_FRONT  = 4'd3;
   localparam logic [3:0] FUNC_PEEK_BACK  = 4'd4;
   localparam logic [3:0] FUNC_PEEK_FRONT = 4'd5;
   localparam logic [3:0] FUNC_GET        = 4'd6;
   localparam logic [3:0] FUNC_SET        = 4'd7;
   localparam logic [3:0] FUNC_INSERT_AT  = 4'd8;
   localparam logic [3:0] FUNC_REMOVE_AT  = 4'd9;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Field widths fixed by the interface
   localparam int INDEX_W = 7;
   localparam int COUNT_W = 7;

   // Per-cell update codes
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_WRITE  = 2'd1;
   localparam logic [1:0] CELL_INSERT = 2'd2;
   localparam logic [1:0] CELL_REMOVE = 2'd3;

   typedef struct packed {
      logic        [3:0]         func;
      logic        [INDEX_W-1:0] index;
      logic signed [31:0]        value;
   } req_type;

   typedef struct packed {
      logic signed [31:0]        data;
      logic        [1:0]         status;
      logic        [COUNT_W-1:0] count;
   } rsp_type;

   typedef struct packed {
      logic        [1:0]  op;
      logic signed [31:0] value;
   } cell_cmd_type;

endpackage
`default_nettype wire

### sv/idq_cell.sv
`default_nettype none
module idq_cell
   import idq_pkg::*;
#(
   parameter int POS_W = 6,
   parameter int INDEX = 0
) (
   input  wire logic                clock,
   input  wire cell_cmd_type        cmd,
   input  wire logic [POS_W-1:0]    pos,
   input  wire logic [POS_W-1:0]    rd_pos,
   input  wire logic signed [31:0]  left_data,
   input  wire logic signed [31:0]  right_data,
   output      logic signed [31:0]  cell_data,
   output      logic signed [31:0]  rd_data
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (cmd.op)
         CELL_WRITE: begin
            if (MY_POS == pos) value_in = cmd.value;
         end
         CELL_INSERT: begin
            // shift toward the back: take the left neighbor past the gap
            if (MY_POS > pos) value_in = left_data;
            else if (MY_POS == pos) value_in = cmd.value;
         end
         CELL_REMOVE: begin
            // close the gap: take the right neighbor
            if (MY_POS >= pos) value_in = right_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_data = value_ff;
   assign rd_data   = (rd_pos == MY_POS) ? value_ff : 32'sd0;

endmodule
`default_nettype wire

### sv/indexed_deque.sv
// The result of an accepted item is registered in the output register in the cycle after acceptance.
// Throughput: one item per cycle; every cell shifts or writes in parallel, and
// the only stall is a result held in the output register while rsp_stall is high.
// Reset: synchronous, active high; clears the count, the output valid and the
// empty marker. Cell contents are not cleared and no clearing pass is run.
`default_nettype none
module indexed_deque
   import idq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire req_type             req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      rsp_type             rsp_data,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic signed [31:0]  csr_data
);

   localparam int POS_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   // common width for comparing the 7-bit index against the count
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // Configuration: the register is always ready
   logic signed [31:0] marker_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= 32'sd0;
      end else if (csr_valid && csr_ready) begin
         marker_ff <= csr_data;
      end
   end

   // Handshake: accept whenever the output register is free or being drained
   logic rsp_valid_ff;
   logic req_accept;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Chain of cells
   cell_cmd_type       cmd;
   logic [POS_W-1:0]   cmd_pos;
   logic [POS_W-1:0]   rd_pos;
   logic signed [31:0] cell_data [DEPTH];
   logic signed [31:0] cell_rd   [DEPTH];
   logic signed [31:0] rd_value;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [31:0] left_in;
         logic signed [31:0] right_in;
         if (g == 0) begin : g_first
            assign left_in = 32'sd0;
         end else begin : g_mid_l
            assign left_in = cell_data[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_in = 32'sd0;
         end else begin : g_mid_r
            assign right_in = cell_data[g+1];
         end
         idq_cell #(
            .POS_W (POS_W),
            .INDEX (g)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .pos        (cmd_pos),
            .rd_pos     (rd_pos),
            .left_data  (left_in),
            .right_data (right_in),
            .cell_data  (cell_data[g]),
            .rd_data    (cell_rd[g])
         );
      end
   endgenerate

   // Only the addressed cell drives a nonzero read value: OR them together
   always_comb begin
      rd_value = 32'sd0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_value = rd_value | cell_rd[i];
      end
   end

   // Decode the item
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [CNT_W-1:0]   cnt_next;
   logic [CMP_W-1:0]   cnt_cmp;
   logic [CMP_W-1:0]   idx_cmp;
   logic [POS_W-1:0]   last_pos;
   logic [POS_W-1:0]   idx_pos;
   logic [1:0]         op_sel;
   logic signed [31:0] res_data;
   logic [1:0]         res_status;
   logic               full;
   logic               empty;

   assign full     = (cnt_ff == FULL_CNT);
   assign empty    = (cnt_ff == '0);
   assign cnt_cmp  = CMP_W'(cnt_ff);
   assign idx_cmp  = CMP_W'(req_data.index);
   assign last_pos = POS_W'(cnt_ff - CNT_W'(1));
   assign idx_pos  = POS_W'(req_data.index);

   always_comb begin
      op_sel     = CELL_HOLD;
      cmd_pos    = '0;
      rd_pos     = '0;
      res_data   = 32'sd0;
      res_status = STATUS_OK;
      cnt_next   = cnt_ff;
      unique case (req_data.func)
         FUNC_PUSH_BACK: begin
            if (full) begin
               res_status = STATUS_FULL;
            end else begin
               op_sel   = CELL_WRITE;
               cmd_pos  = POS_W'(cnt_ff);
               cnt_next = cnt_ff + CNT_W'(1);
            end
         end
         FUNC_PUSH_FRONT: begin
            if (full) begin
               res_status = STATUS_FULL;
            end else begin
               op_sel   = CELL_INSERT;
               cnt_next = cnt_ff + CNT_W'(1);
            end
         end
         FUNC_POP_BACK: begin
            if (empty) begin
               res_data   = marker_ff;
               res_status = STATUS_RANGE;
            end else begin
               // drop the back element: no shift, just shrink the count
               rd_pos   = last_pos;
               res_data = rd_value;
               cnt_next = cnt_ff - CNT_W'(1);
            end
         end
         FUNC_POP_FRONT: begin
            if (empty) begin
               res_data   = marker_ff;
               res_status = STATUS_RANGE;
            end else begin
               op_sel   = CELL_REMOVE;
               res_data = rd_value;
               cnt_next = cnt_ff - CNT_W'(1);
            end
         end
         FUNC_PEEK_BACK: begin
            if (empty) begin
               res_data   = marker_ff;
               res_status = STATUS_RANGE;
            end else begin
               rd_pos   = last_pos;
               res_data = rd_value;
            end
         end
         FUNC_PEEK_FRONT: begin
            if (empty) begin
               res_data   = marker_ff;
               res_status = STATUS_RANGE;
            end else begin
               res_data = rd_value;
            end
         end
         FUNC_GET: begin
            if (idx_cmp >= cnt_cmp) begin
               res_data   = marker_ff;
               res_status = STATUS_RANGE;
            end else begin
               rd_pos   = idx_pos;
               res_data = rd_value;
            end
         end
         FUNC_REMOVE_AT: begin
            if (idx_cmp >= cnt_cmp) begin
               res_data   = marker_ff;
               res_status = STATUS_RANGE;
            end else begin
               rd_pos   = idx_pos;
               cmd_pos  = idx_pos;
               op_sel   = CELL_REMOVE;
               res_data = rd_value;
               cnt_next = cnt_ff - CNT_W'(1);
            end
         end
         FUNC_SET: begin
            if (idx_cmp < cnt_cmp) begin
               op_sel  = CELL_WRITE;
               cmd_pos = idx_pos;
            end else if (idx_cmp > cnt_cmp) begin
               res_status = STATUS_RANGE;
            end else if (full) begin
               res_status = STATUS_FULL;
            end else begin
               // set at the count appends at the back
               op_sel   = CELL_WRITE;
               cmd_pos  = idx_pos;
               cnt_next = cnt_ff + CNT_W'(1);
            end
         end
         FUNC_INSERT_AT: begin
            if (idx_cmp > cnt_cmp) begin
               res_status = STATUS_RANGE;
            end else if (full) begin
               res_status = STATUS_FULL;
            end else begin
               op_sel   = CELL_INSERT;
               cmd_pos  = idx_pos;
               cnt_next = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            // unused codes leave everything as is
         end
      endcase
   end

   // Hold the cells unless an item is taken this cycle
   assign cmd.op    = req_accept ? op_sel : CELL_HOLD;
   assign cmd.value = req_data.value;
   assign cnt_in    = req_accept ? cnt_next : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Output register
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    rsp_valid_in;

   always_comb begin
      rsp_data_in.data   = res_data;
      rsp_data_in.status = res_status;
      rsp_data_in.count  = COUNT_W'(CMP_W'(cnt_in));
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
